// ===== rtl/adpe_pkg.sv =====
package adpe_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 4;
  localparam int unsigned MaskW = 4;
  localparam int unsigned FlagW = 4;

  typedef logic [CmdW-1:0] cmd_t;

  localparam cmd_t OP_AND   = 4'b0000;
  localparam cmd_t OP_EOR   = 4'b0001;
  localparam cmd_t OP_SUB   = 4'b0010;
  localparam cmd_t OP_RSB   = 4'b0011;
  localparam cmd_t OP_ADD   = 4'b0100;
  localparam cmd_t OP_MRS   = 4'b1000;
  localparam cmd_t OP_MSR_A = 4'b1001;
  localparam cmd_t OP_CMP   = 4'b1010;
  localparam cmd_t OP_MSR_B = 4'b1011;
  localparam cmd_t OP_ORR   = 4'b1100;
  localparam cmd_t OP_MOV   = 4'b1101;
  localparam cmd_t OP_BIC   = 4'b1110;
  localparam cmd_t OP_MVN   = 4'b1111;

  localparam logic [4:0] MODE_SYS = 5'b11111;

  // status bit positions
  localparam int unsigned BitN = 31;
  localparam int unsigned BitZ = 30;
  localparam int unsigned BitC = 29;
  localparam int unsigned BitV = 28;

  typedef struct packed {
    cmd_t             command;
    logic             is_multiply;
    logic             set_flags;
    logic             use_saved;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic             shifter_carry;
    logic [MaskW-1:0] psr_bytes;
    logic             dest_is_pc;
    logic             cond_pass;
  } adpe_item_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             write_dest;
    logic [DataW-1:0] status_next;
    logic [DataW-1:0] saved_next;
  } adpe_res_t;

  function automatic logic [DataW-1:0] bytes_from_mask(input logic [MaskW-1:0] m);
    logic [DataW-1:0] bm;
    bm = '0;
    for (int i = 0; i < MaskW; i++) begin
      bm[i*8 +: 8] = {8{m[i]}};
    end
    return bm;
  endfunction

endpackage

// ===== rtl/adpe_if.sv =====
interface adpe_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic        is_multiply;
  logic        set_flags;
  logic        use_saved;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        shifter_carry;
  logic [3:0]  psr_bytes;
  logic        dest_is_pc;
  logic        cond_pass;

  modport source (
    output valid, command, is_multiply, set_flags, use_saved, operand_a, operand_b,
           shifter_carry, psr_bytes, dest_is_pc, cond_pass,
    input  ready
  );
  modport sink (
    input  valid, command, is_multiply, set_flags, use_saved, operand_a, operand_b,
           shifter_carry, psr_bytes, dest_is_pc, cond_pass,
    output ready
  );
endinterface

interface adpe_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        write_dest;
  logic [3:0]  flags_nzcv;

  modport source (
    output valid, result_value, write_dest, flags_nzcv,
    input  ready
  );
  modport sink (
    input  valid, result_value, write_dest, flags_nzcv,
    output ready
  );
endinterface

// ===== rtl/arm_data_processing_execute_unit.sv =====
// Channel  Dir  Payload
// req      in   command, is_multiply, set_flags, use_saved, operand_a/b,
//               shifter_carry, psr_bytes, dest_is_pc, cond_pass
// rsp      out  result_value, write_dest, flags_nzcv
//
// Input register, then the ALU cloud and the result register, which also
// updates CPSR/SPSR. One item per cycle sustained while rsp is not stalled;
// rsp.valid rises as the item leaves the input register. Status lands with
// the result, so the next item always sees the flags left by the one before it.
// rst (synchronous) clears the stage valids, CPSR and SPSR.
// A stalled rsp freezes both stages; one item is absorbed behind it.
module arm_data_processing_execute_unit (
  input logic        clk,
  input logic        rst,
  adpe_req_if.sink   req,
  adpe_rsp_if.source rsp
);
  import adpe_pkg::*;

  adpe_item_t       stage;        // input register
  logic             stage_valid;
  logic             adv;          // stage 1 moves into result register
  logic             out_free;
  logic [DataW-1:0] status;       // CPSR
  logic [DataW-1:0] saved;        // SPSR
  adpe_res_t        alu_res;

  assign out_free  = !rsp.valid || rsp.ready;
  assign adv       = stage_valid && out_free;
  assign req.ready = !stage_valid || out_free;

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage.command       <= req.command;
      stage.is_multiply   <= req.is_multiply;
      stage.set_flags     <= req.set_flags;
      stage.use_saved     <= req.use_saved;
      stage.operand_a     <= req.operand_a;
      stage.operand_b     <= req.operand_b;
      stage.shifter_carry <= req.shifter_carry;
      stage.psr_bytes     <= req.psr_bytes;
      stage.dest_is_pc    <= req.dest_is_pc;
      stage.cond_pass     <= req.cond_pass;
    end
  end

  adpe_alu u_alu (
    .item   (stage),
    .status (status),
    .saved  (saved),
    .res    (alu_res)
  );

  // status registers and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= '0;
      saved     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (out_free) begin
        rsp.valid <= stage_valid;
      end
      if (adv) begin
        status <= alu_res.status_next;
        saved  <= alu_res.saved_next;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.result_value <= alu_res.result_value;
      rsp.write_dest   <= alu_res.write_dest;
      rsp.flags_nzcv   <= alu_res.status_next[DataW-1 -: FlagW];
    end
  end

`ifndef SYNTHESIS
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.write_dest |-> rsp.result_value == '0)
    else $error("result value not zero without destination write");

  a_state_only_on_adv: assert property (@(posedge clk) disable iff (rst)
    !$stable(saved) || !$stable(status) |-> $past(adv))
    else $error("status register changed without an item");

  a_flags_track_cpsr: assert property (@(posedge clk) disable iff (rst)
    $past(adv) |-> rsp.flags_nzcv == status[DataW-1 -: FlagW])
    else $error("reported flags differ from CPSR");

  a_ready_low_means_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> stage_valid && rsp.valid)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== rtl/adpe_alu.sv =====
module adpe_alu (
  input  adpe_pkg::adpe_item_t     item,
  input  logic [31:0]              status,
  input  logic [31:0]              saved,
  output adpe_pkg::adpe_res_t      res
);
  import adpe_pkg::*;

  logic [DataW:0]   diff;      // a - b with carry (no borrow) on top
  logic [DataW-1:0] product;
  logic [DataW-1:0] bm;
  logic [DataW-1:0] psr_sel;
  logic [DataW-1:0] movs_st;
  logic [DataW-1:0] cmp_st;

  always_comb begin
    diff    = {1'b0, item.operand_a} + {1'b0, ~item.operand_b} + {{DataW{1'b0}}, 1'b1};
    product = item.operand_a * item.operand_b;
    bm      = bytes_from_mask(item.psr_bytes);
    psr_sel = item.use_saved ? saved : status;

    movs_st       = status;
    movs_st[BitN] = item.operand_a[DataW-1];
    movs_st[BitZ] = (item.operand_a == '0);
    movs_st[BitC] = item.shifter_carry;

    cmp_st       = status;
    cmp_st[BitN] = diff[DataW-1];
    cmp_st[BitZ] = (diff[DataW-1:0] == '0);
    cmp_st[BitC] = diff[DataW];
    cmp_st[BitV] = (item.operand_a[DataW-1] ^ item.operand_b[DataW-1]) &
                   (item.operand_a[DataW-1] ^ diff[DataW-1]);
  end

  always_comb begin
    res.result_value = '0;
    res.write_dest   = 1'b0;
    res.status_next  = status;
    res.saved_next   = saved;
    if (item.cond_pass) begin
      case (item.command)
        OP_MOV: begin
          res.result_value = item.operand_a;
          res.write_dest   = 1'b1;
          if (item.set_flags) begin
            res.status_next = item.dest_is_pc ? saved : movs_st;
          end
        end
        OP_MVN: begin
          res.result_value = ~item.operand_a;
          res.write_dest   = 1'b1;
        end
        OP_ADD: begin
          res.result_value = item.operand_a + item.operand_b;
          res.write_dest   = 1'b1;
        end
        OP_SUB: begin
          res.result_value = diff[DataW-1:0];
          res.write_dest   = 1'b1;
        end
        OP_RSB: begin
          res.result_value = item.operand_b - item.operand_a;
          res.write_dest   = 1'b1;
        end
        OP_ORR: begin
          res.result_value = item.operand_a | item.operand_b;
          res.write_dest   = 1'b1;
        end
        OP_EOR: begin
          res.result_value = item.operand_a ^ item.operand_b;
          res.write_dest   = 1'b1;
        end
        OP_BIC: begin
          res.result_value = item.operand_a & ~item.operand_b;
          res.write_dest   = 1'b1;
        end
        OP_AND: begin
          res.result_value = item.is_multiply ? product
                                              : (item.operand_a & item.operand_b);
          res.write_dest   = 1'b1;
        end
        OP_CMP: begin
          if (item.set_flags) begin
            res.status_next = cmp_st;
          end else begin
            res.result_value = psr_sel;
            res.write_dest   = 1'b1;
          end
        end
        OP_MRS: begin
          res.result_value = psr_sel;
          res.write_dest   = 1'b1;
        end
        OP_MSR_A, OP_MSR_B: begin
          if (!item.use_saved) begin
            res.status_next = (status & ~bm) | (item.operand_a & bm);
          end else if (status[4:0] != MODE_SYS) begin
            res.saved_next = (saved & ~bm) | (item.operand_a & bm);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
